FILE: rtl/core/gne_pkg.sv
// Gate netlist evaluator package: payload structs, gate opcodes, register indexes.
// No dependencies; imported by every module of the block but gne_ram.
package gne_pkg;

   localparam int SRC_W    = 6;   // width of a node or letter index field
   localparam int COUNT_W  = 7;   // width of node_count and selected_count
   localparam int BITS_W   = 64;  // width of selected_bits and output_mask
   localparam int BIT_SEL_W = 6;  // index into selected_bits
   localparam int VEC_W    = 26;  // width of input_vector
   localparam int LETTER_W = 5;   // index into the zero-extended input vector
   localparam int ENTRY_W  = 15;  // stored gate entry

   typedef enum logic [2:0] {
      OP_INPUT = 3'd0,
      OP_NOT   = 3'd1,
      OP_AND   = 3'd2,
      OP_OR    = 3'd3,
      OP_XOR   = 3'd4,
      OP_NOR   = 3'd5,
      OP_NAND  = 3'd6,
      OP_XNOR  = 3'd7
   } node_op_type;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EVAL = 1'b1;

   localparam logic CSR_NODE_COUNT  = 1'b0;
   localparam logic CSR_OUTPUT_MASK = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [SRC_W-1:0]  entry_index;
      node_op_type       node_op;
      logic [SRC_W-1:0]  src_a;
      logic [SRC_W-1:0]  src_b;
      logic [VEC_W-1:0]  input_vector;
   } gne_req_type;

   typedef struct packed {
      logic [BITS_W-1:0]  selected_bits;
      logic [COUNT_W-1:0] selected_count;
      logic               bad_reference;
   } gne_rsp_type;

   typedef struct packed {
      node_op_type      op;
      logic [SRC_W-1:0] src_a;
      logic [SRC_W-1:0] src_b;
   } gate_entry_type;

   // Resolved operands for the shared gate unit.
   typedef struct packed {
      node_op_type op;
      logic        va;
      logic        vb;
      logic        letter;
   } alu_in_type;

endpackage

FILE: rtl/core/gne_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the gate table and the node value store.
module gne_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/gne_gate_alu.sv
// Shared gate unit: computes one node value from resolved operands.
// Depends on gne_pkg for the opcode enum and operand struct.
module gne_gate_alu
   import gne_pkg::*;
(
   input  alu_in_type operands,
   output logic       value
);

   always_comb begin
      case (operands.op)
         OP_INPUT: value = operands.letter;
         OP_NOT:   value = ~operands.va;
         OP_AND:   value = operands.va & operands.vb;
         OP_OR:    value = operands.va | operands.vb;
         OP_XOR:   value = operands.va ^ operands.vb;
         OP_NOR:   value = ~(operands.va | operands.vb);
         OP_NAND:  value = ~(operands.va & operands.vb);
         OP_XNOR:  value = ~(operands.va ^ operands.vb);
         default:  value = 1'b0;
      endcase
   end

endmodule

FILE: rtl/core/gate_netlist_evaluator.sv
// Gate netlist evaluator top level: sequencer, node walk pipeline, result register.
// Depends on gne_pkg, gne_ram and gne_gate_alu.
//
//   channel  dir  handshake               payload
//   req      in   req_valid / req_ready   req_data  (gne_req_type)
//   rsp      out  rsp_valid / rsp_ready   rsp_data  (gne_rsp_type)
//   csr      in   csr_valid / csr_ready   csr_index, csr_wdata
//
// A load transfer writes one gate entry and shows its all-zero result on the
// next cycle. An evaluate transfer walks nodes 0..n-1 (n = node_count capped at
// MAX_NODES) through a three-stage loop (entry fetch, operand fetch, gate unit),
// one node per cycle, and its result shows after the last node passes the gate unit.
// The walk rate is set by the single gate unit and the one write port of the
// node value store. req_ready is high only while idle; a waiting result holds
// until rsp_ready, and the next item is taken the cycle after. Reset returns
// the sequencer to idle and restores node_count = 1 and output_mask = 1.
module gate_netlist_evaluator
   import gne_pkg::*;
#(
   parameter int MAX_NODES  = 64,
   parameter int MAX_INPUTS = 26
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gne_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gne_rsp_type       rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [BITS_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int CNT_W = $clog2(MAX_NODES + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_RUN  = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [COUNT_W-1:0]   node_count_ff;
   logic [MAX_NODES-1:0] mask_ff;

   // Walk control.
   logic             fetch_on_ff, fetch_on_in;
   logic [IDX_W-1:0] fetch_idx_ff, fetch_idx_in;
   logic [IDX_W-1:0] last_idx_ff, last_idx_in;
   logic             r_valid_ff;
   logic [IDX_W-1:0] r_idx_ff;
   logic             x_valid_ff;
   logic [IDX_W-1:0] x_idx_ff;
   gate_entry_type   x_entry_ff;
   logic [VEC_W-1:0] vec_ff, vec_in;
   logic             pv_ff;

   // Result accumulation.
   logic [BITS_W-1:0]  bits_ff, bits_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               bad_ff, bad_in;

   logic               req_fire, rsp_fire;
   logic               is_load, is_eval;
   logic [CNT_W-1:0]   n_sat;
   logic               load_ok;
   logic [ENTRY_W-1:0] gate_rd;
   gate_entry_type     r_entry;
   logic               node_a_rd, node_b_rd;
   gate_entry_type     load_entry;

   logic [SRC_W-1:0]   cur_idx, prev_idx;
   logic               a_ok, b_ok, a_fwd, b_fwd, need_b, node_bad;
   logic               letter_ok;
   logic [31:0]        vec_ext;
   alu_in_type         alu_in;
   logic               node_value;
   logic               last_node;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid & req_ready;
   assign rsp_fire  = rsp_valid & rsp_ready;
   assign is_load   = req_fire & (req_data.kind == KIND_LOAD);
   assign is_eval   = req_fire & (req_data.kind == KIND_EVAL);

   // Cap the walk length at the table depth.
   assign n_sat = (node_count_ff > COUNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                       : node_count_ff[CNT_W-1:0];

   // Drop loads aimed past the table.
   assign load_ok = (COUNT_W'(req_data.entry_index) < COUNT_W'(MAX_NODES));

   assign load_entry.op    = req_data.node_op;
   assign load_entry.src_a = req_data.src_a;
   assign load_entry.src_b = req_data.src_b;

   // ---------------------------------------------------------------------
   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= COUNT_W'(1);
         mask_ff       <= MAX_NODES'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NODE_COUNT:  node_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_OUTPUT_MASK: mask_ff       <= csr_wdata[MAX_NODES-1:0];
            default:         node_count_ff <= node_count_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Gate table: written by load transfers, read one entry per walk cycle.
   gne_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_NODES)
   ) u_gate_ram (
      .clock   (clock),
      .wr_en   (is_load & load_ok),
      .wr_addr (req_data.entry_index[IDX_W-1:0]),
      .wr_data (load_entry),
      .rd_en   (fetch_on_ff),
      .rd_addr (fetch_idx_ff),
      .rd_data (gate_rd)
   );

   assign r_entry = gate_entry_type'(gate_rd);

   // Node value store, duplicated so both sources are read in the same cycle.
   gne_ram #(
      .WIDTH (1),
      .DEPTH (MAX_NODES)
   ) u_node_ram_a (
      .clock   (clock),
      .wr_en   (x_valid_ff),
      .wr_addr (x_idx_ff),
      .wr_data (node_value),
      .rd_en   (r_valid_ff),
      .rd_addr (r_entry.src_a[IDX_W-1:0]),
      .rd_data (node_a_rd)
   );

   gne_ram #(
      .WIDTH (1),
      .DEPTH (MAX_NODES)
   ) u_node_ram_b (
      .clock   (clock),
      .wr_en   (x_valid_ff),
      .wr_addr (x_idx_ff),
      .wr_data (node_value),
      .rd_en   (r_valid_ff),
      .rd_addr (r_entry.src_b[IDX_W-1:0]),
      .rd_data (node_b_rd)
   );

   // ---------------------------------------------------------------------
   // Gate stage: resolve sources, then run the shared gate unit.
   // A source must name an earlier node. The node just before this one was
   // written last cycle, after its read was issued, so forward it instead.
   assign cur_idx  = SRC_W'(x_idx_ff);
   assign prev_idx = SRC_W'(x_idx_ff - IDX_W'(1));
   assign a_ok     = (x_entry_ff.src_a < cur_idx);
   assign b_ok     = (x_entry_ff.src_b < cur_idx);
   assign a_fwd    = (x_entry_ff.src_a == prev_idx);
   assign b_fwd    = (x_entry_ff.src_b == prev_idx);
   assign need_b   = (x_entry_ff.op != OP_INPUT) && (x_entry_ff.op != OP_NOT);
   assign node_bad = (x_entry_ff.op != OP_INPUT) && (!a_ok || (need_b && !b_ok));

   // Letters past the input count read zero.
   assign letter_ok = (x_entry_ff.src_a < SRC_W'(MAX_INPUTS));
   assign vec_ext   = 32'(vec_ff);

   assign alu_in.op     = x_entry_ff.op;
   assign alu_in.va     = a_ok & (a_fwd ? pv_ff : node_a_rd);
   assign alu_in.vb     = b_ok & (b_fwd ? pv_ff : node_b_rd);
   assign alu_in.letter = letter_ok & vec_ext[x_entry_ff.src_a[LETTER_W-1:0]];

   gne_gate_alu u_alu (
      .operands (alu_in),
      .value    (node_value)
   );

   assign last_node = x_valid_ff && (x_idx_ff == last_idx_ff);

   // ---------------------------------------------------------------------
   // Sequencer and walk control.
   always_comb begin
      state_in     = state_ff;
      fetch_on_in  = fetch_on_ff;
      fetch_idx_in = fetch_idx_ff;
      last_idx_in  = last_idx_ff;
      vec_in       = vec_ff;
      bits_in      = bits_ff;
      count_in     = count_ff;
      bad_in       = bad_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               // Clear the result; a load answers with all zeros.
               bits_in  = '0;
               count_in = '0;
               bad_in   = 1'b0;
               vec_in   = req_data.input_vector;
               if (is_eval && (n_sat != '0)) begin
                  state_in     = S_RUN;
                  fetch_on_in  = 1'b1;
                  fetch_idx_in = '0;
                  last_idx_in  = IDX_W'(n_sat - CNT_W'(1));
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_RUN: begin
            if (fetch_on_ff) begin
               fetch_idx_in = fetch_idx_ff + IDX_W'(1);
               if (fetch_idx_ff == last_idx_ff) begin
                  fetch_on_in = 1'b0;
               end
            end
            if (x_valid_ff) begin
               bad_in = bad_ff | node_bad;
               if (mask_ff[x_idx_ff]) begin
                  bits_in[count_ff[BIT_SEL_W-1:0]] = node_value;
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            if (last_node) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fetch_on_ff <= 1'b0;
         r_valid_ff  <= 1'b0;
         x_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fetch_on_ff <= fetch_on_in;
         r_valid_ff  <= fetch_on_ff;
         x_valid_ff  <= r_valid_ff;
      end
   end

   // Payload and walk indexes; all but pv_ff load every cycle.
   always_ff @(posedge clock) begin
      fetch_idx_ff <= fetch_idx_in;
      last_idx_ff  <= last_idx_in;
      vec_ff       <= vec_in;
      r_idx_ff     <= fetch_idx_ff;
      x_idx_ff     <= r_idx_ff;
      x_entry_ff   <= r_entry;
      if (x_valid_ff) begin
         pv_ff <= node_value;
      end
      bits_ff  <= bits_in;
      count_ff <= count_in;
      bad_ff   <= bad_in;
   end

   assign rsp_data.selected_bits  = bits_ff;
   assign rsp_data.selected_count = count_ff;
   assign rsp_data.bad_reference  = bad_ff;

endmodule

FILE: rtl/core/gne_checker.sv
// Port-level checker for the gate netlist evaluator, bound to the top level.
// Depends on gne_pkg for the payload structs.
module gne_checker
   import gne_pkg::*;
#(
   parameter int MAX_NODES = 64
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input gne_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input gne_rsp_type rsp_data
);

   // Hold off new requests while a result waits.
   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result is pending");

   // A load transfer answers next cycle with an all-zero result.
   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.kind == KIND_LOAD)) |=>
         (rsp_valid && (rsp_data.selected_bits == '0) &&
          (rsp_data.selected_count == '0) && !rsp_data.bad_reference))
      else $error("load result missing or nonzero");

   // Count never exceeds the node capacity, and no bits above it are set.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.selected_count <= COUNT_W'(MAX_NODES)) &&
                     ((rsp_data.selected_bits >> rsp_data.selected_count) == '0)))
      else $error("selected bits beyond selected count");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed while stalled");

endmodule

bind gate_netlist_evaluator gne_checker #(
   .MAX_NODES (MAX_NODES)
) u_gne_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for gate_netlist_evaluator: loads gate netlists, evaluates vectors.
// Depends on gne_pkg for payload types, opcodes and register indexes; needs only the RTL.
module testbench;
   import gne_pkg::*;

   localparam int NODES  = 64;
   localparam int EVAL_TAIL = 80;   // cycles past the last result before the verdict

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   gne_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   gne_rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = CSR_NODE_COUNT;
   logic [BITS_W-1:0] csr_wdata = '0;

   gate_netlist_evaluator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the block state and its registers.
   gate_entry_type     gate_copy [NODES];
   bit                 gate_loaded [NODES];
   logic               node_state [NODES];
   logic [COUNT_W-1:0] cfg_count = 7'd1;
   logic [BITS_W-1:0]  cfg_mask = 64'd1;

   // Node reports still owed by the block, oldest first.
   gne_rsp_type node_report_q [$];
   int          fail_count = 0;
   bit          steady = 1'b0;   // set: no idle bursts on either side
   int          ready_gap = 0;

   // Read one gate source; a source at or past the current node is a bad reference.
   function automatic logic src_value(logic [SRC_W-1:0] src, int cur, inout bit bad);
      if (src >= cur) begin
         bad = 1'b1;
         return 1'b0;
      end
      return node_state[src];
   endfunction

   // Walk the stored netlist for one input vector and pack the selected node values.
   function automatic gne_rsp_type evaluate_gates(logic [VEC_W-1:0] vec);
      gne_rsp_type    r;
      gate_entry_type e;
      int             n;
      int             cnt;
      logic           va;
      logic           vb;
      logic           v;
      bit             bad;
      r = '0;
      cnt = 0;
      bad = 1'b0;
      // counts above the node store saturate
      n = (int'(cfg_count) > NODES) ? NODES : int'(cfg_count);
      for (int i = 0; i < n; i++) begin
         e = gate_copy[i];
         va = 1'b0;
         vb = 1'b0;
         v = 1'b0;
         if (e.op == OP_INPUT) begin
            // letters past the input vector read zero, without a bad reference
            v = (e.src_a < VEC_W) ? vec[e.src_a[LETTER_W-1:0]] : 1'b0;
         end else begin
            va = src_value(e.src_a, i, bad);
            if (e.op != OP_NOT) vb = src_value(e.src_b, i, bad);
            case (e.op)
               OP_NOT:  v = ~va;
               OP_AND:  v = va & vb;
               OP_OR:   v = va | vb;
               OP_XOR:  v = va ^ vb;
               OP_NOR:  v = ~(va | vb);
               OP_NAND: v = ~(va & vb);
               OP_XNOR: v = ~(va ^ vb);
               default: v = 1'b0;
            endcase
         end
         node_state[i] = v;
         // mask bits past the walked count are never reached
         if (cfg_mask[i]) begin
            r.selected_bits[cnt] = v;
            cnt++;
         end
      end
      r.selected_count = COUNT_W'(cnt);
      r.bad_reference = bad;
      return r;
   endfunction

   // Update the shadow state for one item; a load reports all zero.
   function automatic gne_rsp_type apply_item(gne_req_type item);
      if (item.kind == KIND_LOAD) begin
         gate_copy[item.entry_index] = '{item.node_op, item.src_a, item.src_b};
         gate_loaded[item.entry_index] = 1'b1;
         return '0;
      end
      return evaluate_gates(item.input_vector);
   endfunction

   // Present one item and hold it until the transfer. Valid stays high on return so a
   // back-to-back item does not drop it within the same step.
   task automatic send_item(gne_req_type item);
      gne_rsp_type owed;
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      owed = apply_item(item);
      node_report_q = {node_report_q, owed};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Random fill for fields a load or evaluate does not use.
   function automatic gne_req_type random_fill();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(gne_req_type)-1:0];
   endfunction

   task automatic load_gate(int idx, node_op_type op, int a, int b);
      gne_req_type it;
      it = random_fill();
      it.kind = KIND_LOAD;
      it.entry_index = SRC_W'(idx);
      it.node_op = op;
      it.src_a = SRC_W'(a);
      it.src_b = SRC_W'(b);
      send_item(it);
   endtask

   // Mostly well-formed gates naming earlier nodes; some forward references and
   // letters past the input vector.
   function automatic gne_req_type random_load(int idx);
      gne_req_type it;
      it = random_fill();
      it.kind = KIND_LOAD;
      it.entry_index = SRC_W'(idx);
      it.node_op = ($urandom_range(0, 3) == 0) ? OP_INPUT
                   : node_op_type'($urandom_range(1, 7));
      if (it.node_op == OP_INPUT) begin
         it.src_a = ($urandom_range(0, 9) == 0) ? SRC_W'($urandom_range(VEC_W, 63))
                    : SRC_W'($urandom_range(0, VEC_W - 1));
      end else if (idx > 0 && $urandom_range(0, 9) != 0) begin
         it.src_a = SRC_W'($urandom_range(0, idx - 1));
         it.src_b = SRC_W'($urandom_range(0, idx - 1));
      end
      return it;
   endfunction

   // Evaluate, first loading any entry of the walked range that was never written.
   task automatic send_eval(logic [VEC_W-1:0] vec);
      gne_req_type it;
      int          n;
      n = (int'(cfg_count) > NODES) ? NODES : int'(cfg_count);
      for (int i = 0; i < n; i++)
         if (!gate_loaded[i]) send_item(random_load(i));
      it = random_fill();
      it.kind = KIND_EVAL;
      it.input_vector = vec;
      send_item(it);
   endtask

   // Drop valid, wait for every owed report, then let the block go idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (node_report_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller drops it after the last write.
   task automatic write_csr(logic idx, logic [BITS_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_NODE_COUNT) cfg_count = value[COUNT_W-1:0];
      else cfg_mask = value;
   endtask

   task automatic apply_setting(logic [COUNT_W-1:0] count, logic [BITS_W-1:0] mask);
      logic [BITS_W-1:0] word;
      settle();
      // upper bits of the count word are don't-care; toggle them anyway
      word = {$urandom, $urandom};
      word[COUNT_W-1:0] = count;
      write_csr(CSR_NODE_COUNT, word);
      write_csr(CSR_OUTPUT_MASK, mask);
      csr_valid <= 1'b0;
   endtask

   // Result side: check every transfer, stall rsp_ready in random bursts.
   always @(posedge clock) begin
      gne_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (node_report_q.size() == 0) begin
            $error("unexpected result transfer: %h", rsp_data);
            fail_count++;
         end else begin
            want = node_report_q.pop_front();
            if (rsp_data.selected_bits !== want.selected_bits) begin
               $error("selected_bits: expected %h, actual %h",
                      want.selected_bits, rsp_data.selected_bits);
               fail_count++;
            end
            if (rsp_data.selected_count !== want.selected_count) begin
               $error("selected_count: expected %0d, actual %0d",
                      want.selected_count, rsp_data.selected_count);
               fail_count++;
            end
            if (rsp_data.bad_reference !== want.bad_reference) begin
               $error("bad_reference: expected %b, actual %b",
                      want.bad_reference, rsp_data.bad_reference);
               fail_count++;
            end
         end
      end
      if (ready_gap > 0) begin
         ready_gap--;
         rsp_ready <= (ready_gap == 0);
      end else if (!steady && !reset && $urandom_range(0, 5) == 0) begin
         ready_gap = $urandom_range(1, 11);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Load a small netlist with every opcode; each load reports all zero.
   task automatic test_load_entries();
      load_gate(0, OP_INPUT, 0, 63);
      load_gate(1, OP_INPUT, VEC_W - 1, 0);
      load_gate(2, OP_INPUT, 63, 63);        // letter past the vector
      load_gate(3, OP_AND,   0, 1);
      load_gate(4, OP_OR,    3, 2);
      load_gate(5, OP_XOR,   4, 0);
      load_gate(6, OP_NOT,   5, 63);
      load_gate(7, OP_NOR,   6, 3);
      load_gate(8, OP_NAND,  7, 6);
      load_gate(9, OP_XNOR,  8, 1);
   endtask

   // Walk the netlist with extreme input vectors and every node selected.
   task automatic test_gate_ops();
      apply_setting(7'd10, '1);
      send_eval('0);
      send_eval('1);
      send_eval(26'h1);
      send_eval(26'h2000000);
   endtask

   // Self and forward references read zero and raise the flag.
   task automatic test_bad_reference();
      load_gate(10, OP_AND, 10, 3);
      load_gate(11, OP_OR,  2, 63);
      apply_setting(7'd12, 64'hAAAA_AAAA_AAAA_AAAA);
      send_eval('1);
      send_eval(26'h155_5555);
   endtask

   // Zero count, saturated count, empty mask, mask past the count.
   task automatic test_count_limits();
      apply_setting(7'd0, '1);
      send_eval('1);
      apply_setting(7'd127, '1);
      send_eval(VEC_W'($urandom));
      apply_setting(7'd64, '0);
      send_eval(VEC_W'($urandom));
      apply_setting(7'd4, '1);
      send_eval('1);
   endtask

   // Phases of random settings, each with a burst of loads and evaluations.
   task automatic test_random_netlists();
      logic [COUNT_W-1:0] count;
      logic [BITS_W-1:0]  mask;
      int                 pick;
      for (int phase = 0; phase < 15; phase++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) count = 7'd0;
         else if (pick == 1) count = 7'd64;
         else if (pick == 2) count = COUNT_W'($urandom_range(65, 127));
         else if (pick < 8) count = COUNT_W'($urandom_range(1, 8));
         else count = COUNT_W'($urandom_range(1, 64));
         pick = $urandom_range(0, 9);
         if (pick == 0) mask = '1;
         else if (pick == 1) mask = '0;
         else if (pick == 2) mask = 64'd1;
         else mask = {$urandom, $urandom};
         apply_setting(count, mask);
         // hold off idling for the closing phases
         steady = (phase >= 12);
         repeat (45) begin
            if ($urandom_range(0, 9) < 4) send_item(random_load($urandom_range(0, NODES - 1)));
            else if ($urandom_range(0, 7) == 0) send_eval('1);
            else send_eval(VEC_W'($urandom));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_load_entries();
      test_gate_ops();
      test_bad_reference();
      test_count_limits();
      test_random_netlists();
      settle();
      repeat (EVAL_TAIL) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Hard limit: several times the slowest correct run.
   initial begin
      #6_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
